// File: src/amdfs_pkg.sv
// shared types and constants of the adjacency matrix depth-first search unit
package amdfs_pkg;

  localparam int NumVertices = 8;
  localparam int VertexW     = $clog2(NumVertices);
  localparam int DepthW      = $clog2(NumVertices + 1);
  localparam int CountW      = 4;
  localparam int CfgIndexW   = 1;
  localparam int CfgDataW    = 4;
  localparam int InDataW     = 16;
  localparam int OutDataW    = 8;

  localparam logic [CfgIndexW-1:0] CfgCoverAll    = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgVertexCount = 1'b1;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRun  = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StStart,
    StStep,
    StFlush
  } amdfs_state_e;

  typedef struct packed {
    logic load_row;
    logic start_run;
    logic visit;
    logic from_start;
    logic pop;
    logic flush;
  } amdfs_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic found;
    logic stack_empty;
    logic stack_room;
    logic emit_ok;
    logic flush_ok;
    logic pending;
    logic cover_all;
  } amdfs_sts_t;

endpackage

// File: src/amdfs_datapath.sv
// datapath: config registers, adjacency rows, visited map, walk stack and result staging
module amdfs_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [amdfs_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [amdfs_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic [amdfs_pkg::VertexW-1:0]         row_index_i,
  input  logic [amdfs_pkg::NumVertices-1:0]     row_bits_i,
  input  logic [amdfs_pkg::VertexW-1:0]         start_vertex_i,
  input  amdfs_pkg::amdfs_cmd_t                 cmd_i,
  output amdfs_pkg::amdfs_sts_t                 sts_o,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [amdfs_pkg::VertexW-1:0]         out_vertex_o,
  output logic                                  out_last_o
);

  localparam int NV = amdfs_pkg::NumVertices;
  localparam int VW = amdfs_pkg::VertexW;
  localparam int DW = amdfs_pkg::DepthW;

  logic                              cover_all_q;
  logic [amdfs_pkg::CountW-1:0]      vcount_q;
  logic [NV-1:0]                     adj_q [NV];
  logic [VW-1:0]                     stack_q [NV];
  logic [DW-1:0]                     depth_q, depth_d;
  logic [NV-1:0]                     visited_q, visited_d;
  logic [VW-1:0]                     start_q;
  logic                              pend_valid_q, pend_valid_d;
  logic [VW-1:0]                     pend_vertex_q;
  logic                              out_valid_q, out_valid_d;
  logic [VW-1:0]                     out_vertex_q;
  logic                              out_last_q;

  logic [DW-1:0]                     n_active;
  logic [NV-1:0]                     active_mask;
  logic [DW-1:0]                     top;
  logic [NV-1:0]                     base_row;
  logic [NV-1:0]                     cand;
  logic [VW-1:0]                     found_idx;
  logic [VW-1:0]                     visit_vertex;

  // clamp vertex count to 1..NumVertices
  always_comb begin
    if (vcount_q == '0) begin
      n_active = DW'(1);
    end else if (32'(vcount_q) > NV) begin
      n_active = DW'(NV);
    end else begin
      n_active = DW'(vcount_q);
    end
    for (int j = 0; j < NV; j++) begin
      active_mask[j] = (j < 32'(n_active));
    end
  end

  assign top      = depth_q - DW'(1);
  assign base_row = (depth_q == '0) ? '1 : adj_q[stack_q[top[VW-1:0]]];
  assign cand     = base_row & ~visited_q & active_mask;

  // lowest set candidate wins
  always_comb begin
    found_idx = '0;
    for (int j = NV - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found_idx = VW'(j);
      end
    end
  end

  assign visit_vertex = cmd_i.from_start ? start_q : found_idx;

  always_comb begin
    visited_d    = visited_q;
    depth_d      = depth_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.start_run) begin
      visited_d = '0;
      depth_d   = '0;
    end
    if (cmd_i.visit) begin
      visited_d    = visited_q | (NV'(1) << visit_vertex);
      depth_d      = depth_q + DW'(1);
      pend_valid_d = 1'b1;
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
      end
    end
    if (cmd_i.pop) begin
      depth_d = depth_q - DW'(1);
    end
    if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
      out_valid_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cover_all_q  <= 1'b0;
      vcount_q     <= amdfs_pkg::CountW'(NV);
      visited_q    <= '0;
      depth_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          amdfs_pkg::CfgCoverAll:    cover_all_q <= cfg_data_i[0];
          amdfs_pkg::CfgVertexCount: vcount_q    <= cfg_data_i;
          default: ;
        endcase
      end
      visited_q    <= visited_d;
      depth_q      <= depth_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row && (32'(row_index_i) < NV)) begin
      adj_q[row_index_i] <= row_bits_i;
    end
    if (cmd_i.start_run) begin
      start_q <= start_vertex_i;
    end
    if (cmd_i.visit) begin
      stack_q[depth_q[VW-1:0]] <= visit_vertex;
      pend_vertex_q            <= visit_vertex;
      if (pend_valid_q) begin
        out_vertex_q <= pend_vertex_q;
        out_last_q   <= 1'b0;
      end
    end
    if (cmd_i.flush) begin
      out_vertex_q <= pend_vertex_q;
      out_last_q   <= 1'b1;
    end
  end

  assign sts_o.start_ok    = (DW'(start_q) < n_active);
  assign sts_o.found       = |cand;
  assign sts_o.stack_empty = (depth_q == '0);
  assign sts_o.stack_room  = (depth_q < n_active);
  assign sts_o.emit_ok     = !pend_valid_q || !out_valid_q || out_ready_i;
  assign sts_o.flush_ok    = !out_valid_q || out_ready_i;
  assign sts_o.pending     = pend_valid_q;
  assign sts_o.cover_all   = cover_all_q;

  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign out_last_o   = out_last_q;

endmodule

// File: src/amdfs_ctrl.sv
// controller: sequences loads, stack pushes and pops, restarts and the final flush
module amdfs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_command_i,
  input  amdfs_pkg::amdfs_sts_t sts_i,
  output amdfs_pkg::amdfs_cmd_t cmd_o
);

  amdfs_pkg::amdfs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amdfs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      amdfs_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i == amdfs_pkg::CmdLoad) begin
            cmd_o.load_row = 1'b1;
          end else begin
            cmd_o.start_run = 1'b1;
            state_d         = amdfs_pkg::StStart;
          end
        end
      end
      amdfs_pkg::StStart: begin
        if (!sts_i.start_ok) begin
          state_d = amdfs_pkg::StStep;
        end else if (sts_i.emit_ok) begin
          cmd_o.visit      = 1'b1;
          cmd_o.from_start = 1'b1;
          state_d          = amdfs_pkg::StStep;
        end
      end
      amdfs_pkg::StStep: begin
        if (!sts_i.stack_empty) begin
          if (sts_i.found && sts_i.stack_room) begin
            cmd_o.visit = sts_i.emit_ok;
          end else begin
            cmd_o.pop = 1'b1;
          end
        end else if (sts_i.cover_all && sts_i.found) begin
          // restart from the lowest unvisited vertex
          cmd_o.visit = sts_i.emit_ok;
        end else begin
          state_d = amdfs_pkg::StFlush;
        end
      end
      amdfs_pkg::StFlush: begin
        if (!sts_i.pending) begin
          state_d = amdfs_pkg::StIdle;
        end else if (sts_i.flush_ok) begin
          cmd_o.flush = 1'b1;
          state_d     = amdfs_pkg::StIdle;
        end
      end
    endcase
  end

endmodule

// File: src/adjacency_matrix_dfs_unit.sv
// Depth-first search over an adjacency matrix of up to eight vertices. A load transfer
// (tuser 0) writes one adjacency row. A run transfer (tuser 1) walks the graph from the
// start vertex, lowest-numbered unvisited neighbor first, and sends one result per newly
// visited vertex, tlast on the final one; with cover_all set the walk restarts from each
// remaining unvisited vertex in index order. A run is accepted, then passes a start step,
// one step per stack push or pop (restarts included), a final empty-stack check and a
// flush step; output back-pressure adds stalls. Rows must be loaded before a run reads
// them.
module adjacency_matrix_dfs_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [amdfs_pkg::InDataW-1:0]       s_axis_tdata,  // row_index, row_bits, start_vertex
  input  logic                                s_axis_tuser,  // command
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [amdfs_pkg::OutDataW-1:0]      m_axis_tdata,  // visited_vertex
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [amdfs_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [amdfs_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int VW = amdfs_pkg::VertexW;
  localparam int NV = amdfs_pkg::NumVertices;

  amdfs_pkg::amdfs_cmd_t cmd;
  amdfs_pkg::amdfs_sts_t sts;
  logic [VW-1:0]         out_vertex;

  assign cfg_ready_o = 1'b1;

  amdfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_command_i(s_axis_tuser),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  amdfs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .row_index_i   (s_axis_tdata[VW-1:0]),
    .row_bits_i    (s_axis_tdata[VW+NV-1:VW]),
    .start_vertex_i(s_axis_tdata[2*VW+NV-1:VW+NV]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_vertex_o  (out_vertex),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = amdfs_pkg::OutDataW'(out_vertex);

endmodule

// File: src/amdfs_checker.sv
// port-level checks of the depth-first search unit and their bind
module amdfs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [amdfs_pkg::OutDataW-1:0]    m_axis_tdata,
  input logic                              m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a run transfer closes the input until the walk ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input open during a run");

  // while idle, only the final result of a run can still wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("non-final result pending while idle");

  // a row load makes no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("row load produced a result");

  // reset empties the output
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind adjacency_matrix_dfs_unit amdfs_checker u_amdfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
